@@ rtl/acmts_pkg.sv @@
// shared types, tier rom and constants for the acm tier selector
package acmts_pkg;

	localparam int TIER_W    = 4;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;
	localparam int QUO_W     = 16;
	localparam int DIV_STEPS = QUO_W;
	localparam int STEP_W    = $clog2(DIV_STEPS);
	localparam int REM_W     = 32;
	localparam int K_W       = 26;
	localparam int D_W       = 15;

	localparam logic [CFG_IDX_W-1:0] CFG_BER_LIMIT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_UP_HYST   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_UP_HOLD   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CP_FRAC   = 3'd3;

	localparam logic signed [12:0] DOWN_MARGIN = 13'sd16;

	typedef struct packed {
		logic signed [9:0] thr;
		logic [11:0]       bw;
		logic [6:0]        sq;
		logic [2:0]        bps;
		logic [1:0]        num;
		logic [2:0]        den;
		logic [2:0]        passes;
		logic [9:0]        win;
		logic [K_W-1:0]    k;
		logic [D_W-1:0]    d;
	} tier_rom_t;

	typedef struct packed {
		logic load;
		logic update;
		logic mul;
		logic chk;
		logic div_step;
		logic emit;
	} acmts_cmd_t;

	typedef struct packed {
		logic out_free;
	} acmts_status_t;

	// k = floor(4*bw/sq)*3*bps*sq*num*85, d = 1600*den*passes
	function automatic tier_rom_t tier_rom(input logic [TIER_W-1:0] t);
		tier_rom_t e;
		case (t)
			4'd0: e = '{-10'sd320,   12'd50,  7'd25, 3'd1, 2'd1, 3'd3, 3'd4, 10'd900,
				26'd51000,    15'd19200};
			4'd1: e = '{-10'sd192,  12'd500,  7'd25, 3'd1, 2'd1, 3'd3, 3'd1, 10'd150,
				26'd510000,   15'd4800};
			4'd2: e = '{-10'sd128, 12'd1000,  7'd25, 3'd1, 2'd1, 3'd2, 3'd1, 10'd120,
				26'd1020000,  15'd3200};
			4'd3: e = '{-10'sd80,  12'd1500,  7'd25, 3'd2, 2'd1, 3'd2, 3'd1, 10'd100,
				26'd3060000,  15'd3200};
			4'd4: e = '{-10'sd32,  12'd2000,  7'd25, 3'd2, 2'd1, 3'd2, 3'd1, 10'd100,
				26'd4080000,  15'd3200};
			4'd5: e = '{10'sd16,   12'd2500,  7'd25, 3'd2, 2'd1, 3'd2, 3'd1, 10'd75,
				26'd5100000,  15'd3200};
			4'd6: e = '{10'sd64,   12'd3000,  7'd50, 3'd3, 2'd3, 3'd4, 3'd1, 10'd75,
				26'd27540000, 15'd6400};
			4'd7: e = '{10'sd112,  12'd3200,  7'd50, 3'd3, 2'd3, 3'd4, 3'd1, 10'd75,
				26'd29376000, 15'd6400};
			default: e = '{10'sd160, 12'd3500, 7'd100, 3'd4, 2'd3, 3'd4, 3'd1, 10'd75,
				26'd42840000, 15'd6400};
		endcase
		return e;
	endfunction

endpackage

@@ rtl/acm_tier_selector_unit.sv @@
// top level of the acm tier selector: configuration registers, sequencer and datapath
// Each transaction walks the sequencer through its states: the accepting edge captures the
// report, then the update state updates tier and good-frame count, the multiply state forms
// the divisor from the tier rom and cyclic prefix fraction, the check state checks for
// overflow, the divide state runs the one-bit-per-cycle restoring divider for the throughput
// estimate and the emit state loads the output register. in_stall stays high until that load,
// so the next transaction is accepted only once that load is done; a result still held in the
// output register by out_stall delays the load for as long as it is held there.
// The input is taken again as soon as the sequencer is idle, while a finished result
// still waits in the output register. Configuration writes are taken at any time
// (cfg_ready is always high) and belong in idle periods.
module acm_tier_selector_unit #(
	parameter int TIER_COUNT = 9
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [acmts_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [acmts_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                operation,
	input  logic signed [11:0]                  snr_db,
	input  logic [15:0]                         bit_error_rate,
	input  logic [3:0]                          tier_request,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [3:0]                          tier_now,
	output logic                                tier_changed,
	output logic                                force_rejected,
	output logic [15:0]                         throughput_bps,
	output logic [11:0]                         bandwidth_hz,
	output logic [6:0]                          spacing_quarter_hz,
	output logic [2:0]                          bits_per_symbol,
	output logic [1:0]                          rate_numerator,
	output logic [2:0]                          rate_denominator,
	output logic [2:0]                          combining_passes,
	output logic [9:0]                          window_tenths_s
);

	logic [15:0]              ber_limit_q;
	logic [7:0]               up_hyst_q;
	logic [7:0]               up_hold_q;
	logic [15:0]              cp_frac_q;
	acmts_pkg::acmts_cmd_t    cmd;
	acmts_pkg::acmts_status_t status;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ber_limit_q <= 16'd655;
			up_hyst_q   <= 8'd32;
			up_hold_q   <= 8'd3;
			cp_frac_q   <= 16'd8192;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				acmts_pkg::CFG_BER_LIMIT: ber_limit_q <= cfg_data;
				acmts_pkg::CFG_UP_HYST:   up_hyst_q   <= cfg_data[7:0];
				acmts_pkg::CFG_UP_HOLD:   up_hold_q   <= cfg_data[7:0];
				acmts_pkg::CFG_CP_FRAC:   cp_frac_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	acmts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	acmts_dp #(
		.TIER_COUNT (TIER_COUNT)
	) u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.status             (status),
		.ber_limit          (ber_limit_q),
		.up_hyst            (up_hyst_q),
		.up_hold            (up_hold_q),
		.cp_frac            (cp_frac_q),
		.operation          (operation),
		.snr_db             (snr_db),
		.bit_error_rate     (bit_error_rate),
		.tier_request       (tier_request),
		.out_stall          (out_stall),
		.out_valid          (out_valid),
		.tier_now           (tier_now),
		.tier_changed       (tier_changed),
		.force_rejected     (force_rejected),
		.throughput_bps     (throughput_bps),
		.bandwidth_hz       (bandwidth_hz),
		.spacing_quarter_hz (spacing_quarter_hz),
		.bits_per_symbol    (bits_per_symbol),
		.rate_numerator     (rate_numerator),
		.rate_denominator   (rate_denominator),
		.combining_passes   (combining_passes),
		.window_tenths_s    (window_tenths_s)
	);

endmodule

@@ rtl/acmts_ctrl.sv @@
// sequencer for the acm tier selector: capture, update, multiply, check, divide, emit
module acmts_ctrl (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  acmts_pkg::acmts_status_t status,
	output acmts_pkg::acmts_cmd_t    cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_UPD  = 3'd1;
	localparam logic [2:0] ST_MUL  = 3'd2;
	localparam logic [2:0] ST_CHK  = 3'd3;
	localparam logic [2:0] ST_DIV  = 3'd4;
	localparam logic [2:0] ST_EMIT = 3'd5;

	logic [2:0]                  state_q;
	logic [2:0]                  state_n;
	logic [acmts_pkg::STEP_W-1:0] step_q;
	logic                        last_step;

	assign last_step = (step_q == acmts_pkg::STEP_W'(acmts_pkg::DIV_STEPS - 1));
	assign in_stall  = (state_q != ST_IDLE);

	always_comb begin
		cmd     = '0;
		state_n = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_n  = ST_UPD;
				end
			end
			ST_UPD: begin
				cmd.update = 1'b1;
				state_n    = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_n = ST_CHK;
			end
			ST_CHK: begin
				cmd.chk = 1'b1;
				state_n = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (last_step) begin
					state_n = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					state_n  = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_n;
			if (cmd.chk) begin
				step_q <= '0;
			end else if (cmd.div_step) begin
				step_q <= step_q + 1'b1;
			end
		end
	end

	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd)) else $error("more than one datapath command");
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> status.out_free) else $error("emit into occupied output");
	a_load_next: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> cmd.update) else $error("update does not follow load");
	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.chk |=> (cmd.div_step && step_q == '0)) else $error("divider start");

endmodule

@@ rtl/acmts_dp.sv @@
// datapath for the acm tier selector: tier state, throughput divider, output register
module acmts_dp #(
	parameter int TIER_COUNT = 9
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  acmts_pkg::acmts_cmd_t     cmd,
	output acmts_pkg::acmts_status_t  status,
	input  logic [15:0]               ber_limit,
	input  logic [7:0]                up_hyst,
	input  logic [7:0]                up_hold,
	input  logic [15:0]               cp_frac,
	input  logic                      operation,
	input  logic signed [11:0]        snr_db,
	input  logic [15:0]               bit_error_rate,
	input  logic [3:0]                tier_request,
	input  logic                      out_stall,
	output logic                      out_valid,
	output logic [3:0]                tier_now,
	output logic                      tier_changed,
	output logic                      force_rejected,
	output logic [15:0]               throughput_bps,
	output logic [11:0]               bandwidth_hz,
	output logic [6:0]                spacing_quarter_hz,
	output logic [2:0]                bits_per_symbol,
	output logic [1:0]                rate_numerator,
	output logic [2:0]                rate_denominator,
	output logic [2:0]                combining_passes,
	output logic [9:0]                window_tenths_s
);

	localparam logic [4:0] TierLimit = 5'(TIER_COUNT);

	logic                         op_q;
	logic signed [11:0]           snr_q;
	logic [15:0]                  ber_q;
	logic [3:0]                   req_q;
	logic [3:0]                   tier_q;
	logic [7:0]                   gfc_q;
	logic                         chg_q;
	logic                         rej_q;
	logic [acmts_pkg::REM_W-1:0]  divisor_q;
	logic [acmts_pkg::REM_W-1:0]  rem_q;
	logic [acmts_pkg::QUO_W-1:0]  quo_q;
	logic                         sat_q;
	logic                         out_valid_q;

	logic [3:0]                   tier_n;
	logic [7:0]                   gfc_n;
	logic [7:0]                   gfc_inc;
	logic                         chg_n;
	logic                         rej_n;
	logic                         done;
	logic [4:0]                   next_w;
	logic                         up_ok;
	logic signed [12:0]           snr_ext;
	logic signed [12:0]           up_thr;
	logic signed [12:0]           dn_thr;
	acmts_pkg::tier_rom_t         cur_e;
	acmts_pkg::tier_rom_t         next_e;
	logic [acmts_pkg::REM_W:0]    rem2;
	logic                         sub_ok;

	assign cur_e   = acmts_pkg::tier_rom(tier_q);
	assign next_e  = acmts_pkg::tier_rom(next_w[3:0]);
	assign next_w  = {1'b0, tier_q} + 5'd1;
	assign up_ok   = (next_w < TierLimit);
	assign snr_ext = {snr_q[11], snr_q};
	assign up_thr  = {{3{next_e.thr[9]}}, next_e.thr} + $signed({5'd0, up_hyst});
	assign dn_thr  = {{3{cur_e.thr[9]}}, cur_e.thr} - acmts_pkg::DOWN_MARGIN;
	assign gfc_inc = (gfc_q == 8'hFF) ? gfc_q : gfc_q + 8'd1;

	assign rem2   = {rem_q, 1'b0};
	assign sub_ok = (rem2 >= {1'b0, divisor_q});

	assign status.out_free = !out_valid_q || !out_stall;
	assign out_valid       = out_valid_q;

	always_comb begin
		tier_n = tier_q;
		gfc_n  = gfc_q;
		chg_n  = 1'b0;
		rej_n  = 1'b0;
		done   = 1'b0;
		if (op_q) begin
			if ({1'b0, req_q} < TierLimit) begin
				tier_n = req_q;
				gfc_n  = '0;
			end else begin
				rej_n = 1'b1;
			end
		end else if ((ber_q > ber_limit) && (tier_q != '0)) begin
			tier_n = tier_q - 4'd1;
			gfc_n  = '0;
			chg_n  = 1'b1;
		end else begin
			if (up_ok) begin
				if (snr_ext >= up_thr) begin
					gfc_n = gfc_inc;
					if (gfc_inc >= up_hold) begin
						tier_n = next_w[3:0];
						gfc_n  = '0;
						chg_n  = 1'b1;
						done   = 1'b1;
					end
				end else begin
					gfc_n = '0;
				end
			end
			if (!done && (tier_q != '0) && (snr_ext < dn_thr)) begin
				tier_n = tier_q - 4'd1;
				gfc_n  = '0;
				chg_n  = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tier_q      <= '0;
			gfc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.update) begin
				tier_q <= tier_n;
				gfc_q  <= gfc_n;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= operation;
			snr_q <= snr_db;
			ber_q <= bit_error_rate;
			req_q <= tier_request;
		end
		if (cmd.update) begin
			chg_q <= chg_n;
			rej_q <= rej_n;
		end
		if (cmd.mul) begin
			divisor_q <= cur_e.d * {1'b1, cp_frac};
			rem_q     <= {{(acmts_pkg::REM_W - acmts_pkg::K_W){1'b0}}, cur_e.k};
		end
		if (cmd.chk) begin
			sat_q <= (rem_q >= divisor_q);
			quo_q <= '0;
		end
		if (cmd.div_step) begin
			if (sub_ok) begin
				rem_q <= acmts_pkg::REM_W'(rem2 - {1'b0, divisor_q});
			end else begin
				rem_q <= rem2[acmts_pkg::REM_W-1:0];
			end
			quo_q <= {quo_q[acmts_pkg::QUO_W-2:0], sub_ok};
		end
		if (cmd.emit) begin
			tier_now           <= tier_q;
			tier_changed       <= chg_q;
			force_rejected     <= rej_q;
			throughput_bps     <= sat_q ? '1 : quo_q;
			bandwidth_hz       <= cur_e.bw;
			spacing_quarter_hz <= cur_e.sq;
			bits_per_symbol    <= cur_e.bps;
			rate_numerator     <= cur_e.num;
			rate_denominator   <= cur_e.den;
			combining_passes   <= cur_e.passes;
			window_tenths_s    <= cur_e.win;
		end
	end

	a_tier_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, tier_q} < TierLimit) else $error("tier out of range");
	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> (out_valid_q && tier_now == $past(tier_q)))
		else $error("emitted transaction lost");
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.div_step && !sat_q) |-> (rem_q < divisor_q)) else $error("divider remainder");
	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !(chg_q && rej_q)) else $error("changed and rejected both set");

endmodule

@@ bench/tb_top.sv @@
// testbench for acm_tier_selector_unit: directed and random tier traffic with a local predictor
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_TIERS     = 9;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_SLACK = 30;
	localparam int REPORT_MAX  = 10;

	localparam logic OP_REPORT = 1'b0;
	localparam logic OP_FORCE  = 1'b1;

	localparam logic [acmts_pkg::CFG_IDX_W-1:0] CFG_UNUSED_LO = 3'd4;

	typedef enum int {FLOW, CHOPPY, CLOGGED} stall_mode_e;
	typedef enum int {KIND_GOOD, KIND_BER_HIGH, KIND_SNR_LOW, KIND_EDGE, KIND_FORCE,
		KIND_NOISE} frame_kind_e;

	typedef struct packed {
		logic        op;
		logic [11:0] snr;
		logic [15:0] ber;
		logic [3:0]  req;
	} frame_item_t;

	typedef struct packed {
		logic [3:0]  tier;
		logic        changed;
		logic        rejected;
		logic [15:0] thr_bps;
		logic [11:0] bw;
		logic [6:0]  sq;
		logic [2:0]  bps;
		logic [1:0]  rnum;
		logic [2:0]  rden;
		logic [2:0]  passes;
		logic [9:0]  win;
	} link_result_t;

	typedef struct {
		int thr;
		int bw;
		int sq;
		int bps;
		int num;
		int den;
		int passes;
		int win;
	} tier_info_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [acmts_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [acmts_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        operation = 1'b0;
	logic [11:0] snr_db = '0;
	logic [15:0] bit_error_rate = '0;
	logic [3:0]  tier_request = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [3:0]  tier_now;
	logic        tier_changed;
	logic        force_rejected;
	logic [15:0] throughput_bps;
	logic [11:0] bandwidth_hz;
	logic [6:0]  spacing_quarter_hz;
	logic [2:0]  bits_per_symbol;
	logic [1:0]  rate_numerator;
	logic [2:0]  rate_denominator;
	logic [2:0]  combining_passes;
	logic [9:0]  window_tenths_s;

	// predictor state and register copies
	int ber_limit = 655;
	int up_hyst = 32;
	int up_hold = 3;
	int cp_frac = 8192;
	int tier_st = 0;
	int good_cnt = 0;

	link_result_t awaited_tier_reports[$];

	int mismatch_count = 0;
	int results_checked = 0;
	int items_sent = 0;
	int forces_sent = 0;
	int rejects_seen = 0;
	int changes_seen = 0;
	int top_reached = 0;
	int settings_used = 1;
	int burst_left = 0;
	int cycle_count = 0;
	stall_mode_e stall_mode = FLOW;
	int stall_span = 0;

	acm_tier_selector_unit #(.TIER_COUNT(N_TIERS)) dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_valid          (cfg_valid),
		.cfg_ready          (cfg_ready),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.in_valid           (in_valid),
		.in_stall           (in_stall),
		.operation          (operation),
		.snr_db             (snr_db),
		.bit_error_rate     (bit_error_rate),
		.tier_request       (tier_request),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.tier_now           (tier_now),
		.tier_changed       (tier_changed),
		.force_rejected     (force_rejected),
		.throughput_bps     (throughput_bps),
		.bandwidth_hz       (bandwidth_hz),
		.spacing_quarter_hz (spacing_quarter_hz),
		.bits_per_symbol    (bits_per_symbol),
		.rate_numerator     (rate_numerator),
		.rate_denominator   (rate_denominator),
		.combining_passes   (combining_passes),
		.window_tenths_s    (window_tenths_s)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				awaited_tier_reports.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	// receiver backpressure
	always @(posedge clk) begin
		if (stall_span == 0) begin
			stall_mode = stall_mode_e'($urandom_range(0, 2));
			stall_span = $urandom_range(10, 150);
		end else begin
			stall_span--;
		end
		case (stall_mode)
			FLOW:    out_stall <= 1'b0;
			CHOPPY:  out_stall <= 1'($urandom_range(0, 1));
			default: out_stall <= ($urandom_range(0, 3) != 0);
		endcase
	end

	function automatic tier_info_t tier_info(input int t);
		tier_info_t e;
		case (t)
			0:       e = '{-320,   50,  25, 1, 1, 3, 4, 900};
			1:       e = '{-192,  500,  25, 1, 1, 3, 1, 150};
			2:       e = '{-128, 1000,  25, 1, 1, 2, 1, 120};
			3:       e = '{ -80, 1500,  25, 2, 1, 2, 1, 100};
			4:       e = '{ -32, 2000,  25, 2, 1, 2, 1, 100};
			5:       e = '{  16, 2500,  25, 2, 1, 2, 1,  75};
			6:       e = '{  64, 3000,  50, 3, 3, 4, 1,  75};
			7:       e = '{ 112, 3200,  50, 3, 3, 4, 1,  75};
			default: e = '{ 160, 3500, 100, 4, 3, 4, 1,  75};
		endcase
		return e;
	endfunction

	function automatic int rand_between(input int lo, input int hi);
		return lo + int'($urandom_range(0, hi - lo));
	endfunction

	// snr a report needs to count as a good frame; at the top tier, the downgrade edge
	function automatic int upgrade_snr();
		if (tier_st + 1 < N_TIERS)
			return tier_info(tier_st + 1).thr + up_hyst;
		return tier_info(tier_st).thr - 16;
	endfunction

	function automatic link_result_t advance_link_tier(input frame_item_t it);
		link_result_t r;
		tier_info_t e;
		int snr_v;
		int up_v;
		logic raised;
		longint unsigned nsc;
		longint unsigned n_v;
		longint unsigned d_v;
		longint unsigned q_v;
		r = '0;
		raised = 1'b0;
		snr_v = int'($signed(it.snr));
		if (it.op == OP_FORCE) begin
			forces_sent++;
			if (int'(it.req) >= N_TIERS) begin
				r.rejected = 1'b1;
			end else begin
				tier_st = int'(it.req);
				good_cnt = 0;
			end
		end else if (int'(it.ber) > ber_limit && tier_st > 0) begin
			tier_st--;
			good_cnt = 0;
			r.changed = 1'b1;
		end else begin
			if (tier_st + 1 < N_TIERS) begin
				up_v = tier_info(tier_st + 1).thr + up_hyst;
				if (snr_v >= up_v) begin
					if (good_cnt < 255)
						good_cnt++;
					if (good_cnt >= up_hold) begin
						tier_st++;
						good_cnt = 0;
						r.changed = 1'b1;
						raised = 1'b1;
					end
				end else begin
					good_cnt = 0;
				end
			end
			if (!raised && tier_st > 0 && snr_v < tier_info(tier_st).thr - 16) begin
				tier_st--;
				good_cnt = 0;
				r.changed = 1'b1;
			end
		end
		e = tier_info(tier_st);
		nsc = longint'(e.bw * 4 / e.sq);
		n_v = nsc * 3 * e.bps * e.sq * e.num * 85 * 65536;
		d_v = longint'(1600 * e.den * e.passes) * (65536 + cp_frac);
		q_v = n_v / d_v;
		if (q_v > 65535)
			q_v = 65535;
		r.tier = 4'(tier_st);
		r.thr_bps = 16'(q_v);
		r.bw = 12'(e.bw);
		r.sq = 7'(e.sq);
		r.bps = 3'(e.bps);
		r.rnum = 2'(e.num);
		r.rden = 3'(e.den);
		r.passes = 3'(e.passes);
		r.win = 10'(e.win);
		if (r.changed)
			changes_seen++;
		if (r.rejected)
			rejects_seen++;
		if (tier_st > top_reached)
			top_reached = tier_st;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [15:0] want,
		input logic [15:0] have);
		if (have !== want) begin
			mismatch_count++;
			if (mismatch_count <= REPORT_MAX)
				$display("mismatch on result %0d: %s expected %0d got %0d", results_checked,
					name, want, have);
		end
	endtask

	always @(posedge clk) begin
		link_result_t got;
		link_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = {tier_now, tier_changed, force_rejected, throughput_bps, bandwidth_hz,
				spacing_quarter_hz, bits_per_symbol, rate_numerator, rate_denominator,
				combining_passes, window_tenths_s};
			if (awaited_tier_reports.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_MAX)
					$display("unexpected result transaction: tier %0d", tier_now);
			end else begin
				want = awaited_tier_reports.pop_front();
				check_field("tier_now", want.tier, got.tier);
				check_field("tier_changed", want.changed, got.changed);
				check_field("force_rejected", want.rejected, got.rejected);
				check_field("throughput_bps", want.thr_bps, got.thr_bps);
				check_field("bandwidth_hz", want.bw, got.bw);
				check_field("spacing_quarter_hz", want.sq, got.sq);
				check_field("bits_per_symbol", want.bps, got.bps);
				check_field("rate_numerator", want.rnum, got.rnum);
				check_field("rate_denominator", want.rden, got.rden);
				check_field("combining_passes", want.passes, got.passes);
				check_field("window_tenths_s", want.win, got.win);
			end
			results_checked++;
		end
	end

	// sender bursts: valid stays high inside a burst, gaps lower it
	task automatic send_item(input frame_item_t it);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		operation <= it.op;
		snr_db <= it.snr;
		bit_error_rate <= it.ber;
		tier_request <= it.req;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		awaited_tier_reports.push_back(advance_link_tier(it));
		items_sent++;
	endtask

	task automatic send_report(input int snr, input int ber);
		frame_item_t it;
		it.op = OP_REPORT;
		it.snr = 12'(snr);
		it.ber = 16'(ber);
		it.req = 4'($urandom);
		send_item(it);
	endtask

	task automatic send_force(input int req);
		frame_item_t it;
		it.op = OP_FORCE;
		it.snr = 12'($urandom);
		it.ber = 16'($urandom);
		it.req = 4'(req);
		send_item(it);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (awaited_tier_reports.size() != 0)
			@(posedge clk);
		repeat (DRAIN_SLACK) @(posedge clk);
	endtask

	task automatic write_register(input logic [acmts_pkg::CFG_IDX_W-1:0] idx,
		input logic [acmts_pkg::CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			acmts_pkg::CFG_BER_LIMIT: ber_limit = int'(data);
			acmts_pkg::CFG_UP_HYST:   up_hyst = int'(data[7:0]);
			acmts_pkg::CFG_UP_HOLD:   up_hold = int'(data[7:0]);
			acmts_pkg::CFG_CP_FRAC:   cp_frac = int'(data);
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_settings(input logic [15:0] limit, input logic [15:0] hyst,
		input logic [15:0] hold, input logic [15:0] cp);
		drain_results();
		write_register(acmts_pkg::CFG_BER_LIMIT, limit);
		write_register(acmts_pkg::CFG_UP_HYST, hyst);
		write_register(acmts_pkg::CFG_UP_HOLD, hold);
		write_register(acmts_pkg::CFG_CP_FRAC, cp);
		settings_used++;
	endtask

	task automatic run_link_traffic(input int count, input int good_pct);
		frame_item_t it;
		frame_kind_e kind;
		int up_v;
		int thr_v;
		repeat (count) begin
			kind = (int'($urandom_range(0, 99)) < good_pct) ? KIND_GOOD :
				frame_kind_e'($urandom_range(1, 5));
			up_v = upgrade_snr();
			thr_v = tier_info(tier_st).thr;
			it.op = OP_REPORT;
			it.snr = 12'($urandom);
			it.ber = 16'($urandom_range(0, ber_limit));
			it.req = 4'($urandom);
			case (kind)
				KIND_GOOD: begin
					it.snr = 12'($urandom_range(0, 1) ? up_v + int'($urandom_range(0, 3)) :
						rand_between(up_v, 2047));
				end
				KIND_BER_HIGH: begin
					if (ber_limit < 65535)
						it.ber = 16'($urandom_range(0, 1) ? ber_limit + 1 :
							rand_between(ber_limit + 1, 65535));
				end
				KIND_SNR_LOW: begin
					it.snr = 12'(rand_between(-2048, thr_v - 17));
				end
				KIND_EDGE: begin
					it.ber = 16'(ber_limit);
					case ($urandom_range(0, 3))
						0:       it.snr = 12'(thr_v - 16);
						1:       it.snr = 12'(thr_v - 17);
						2:       it.snr = 12'(up_v - 1);
						default: it.snr = 12'(up_v);
					endcase
				end
				KIND_FORCE: begin
					it.op = OP_FORCE;
					it.ber = 16'($urandom);
				end
				default: begin
					it.op = 1'($urandom_range(0, 1));
					it.ber = 16'($urandom);
				end
			endcase
			send_item(it);
		end
	endtask

	task automatic test_force_tier();
		send_force(15);
		send_force(N_TIERS);
		send_force(N_TIERS - 1);
		send_force(0);
	endtask

	task automatic test_ber_downgrade();
		send_force(2);
		send_report(0, ber_limit + 1);
		send_report(0, ber_limit);
		send_force(0);
		send_report(-2048, 65535);
	endtask

	task automatic test_snr_downgrade();
		send_force(7);
		send_report(tier_info(7).thr - 16, 0);
		send_report(tier_info(7).thr - 17, 0);
	endtask

	task automatic test_upgrade_hold();
		send_force(0);
		repeat (2) send_report(tier_info(1).thr + up_hyst, 0);
		send_report(tier_info(1).thr + up_hyst - 1, 0);
		repeat (3) send_report(tier_info(1).thr + up_hyst, 0);
	endtask

	task automatic test_top_tier();
		send_force(N_TIERS - 1);
		send_report(2047, 0);
		send_report(2047, ber_limit);
	endtask

	task automatic test_default_traffic();
		run_link_traffic(150, 55);
	endtask

	// zero hold acts like a hold of one
	task automatic test_register_extremes();
		apply_settings(16'd0, 16'd0, 16'd1, 16'd0);
		run_link_traffic(100, 50);
		apply_settings(16'd65535, 16'd255, 16'd0, 16'd65535);
		run_link_traffic(100, 55);
	endtask

	task automatic test_long_hold();
		apply_settings(16'd40000, 16'd10, 16'd255, 16'd30000);
		run_link_traffic(270, 100);
	endtask

	// upper byte of the 8-bit registers carries junk
	task automatic test_random_registers();
		repeat (2) begin
			apply_settings(16'($urandom), {8'($urandom), 8'($urandom)},
				{8'($urandom), 8'($urandom_range(0, 8))}, 16'($urandom));
			write_register(CFG_UNUSED_LO + 3'($urandom_range(0, 3)), 16'($urandom));
			run_link_traffic(90, 60);
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_force_tier();
		test_ber_downgrade();
		test_snr_downgrade();
		test_upgrade_hold();
		test_top_tier();
		test_default_traffic();
		test_register_extremes();
		test_long_hold();
		test_random_registers();
		drain_results();
		$display("covered %0d transactions (%0d forces, %0d rejected), %0d tier changes, %s %0d",
			items_sent, forces_sent, rejects_seen, changes_seen, "top tier", top_reached);
		$display("checked %0d results over %0d register settings, %0d mismatches",
			results_checked, settings_used, mismatch_count);
		if (mismatch_count == 0 && awaited_tier_reports.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
